/* hw/rtl/modular_mul_div_unit_defines.svh */
// Assertion macros shared by the checker of the modular arithmetic unit.
`ifndef MODULAR_MUL_DIV_UNIT_DEFINES_SVH
`define MODULAR_MUL_DIV_UNIT_DEFINES_SVH

// Implication checked at every rising clock edge, disabled during reset.
`define MMD_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled during reset.
`define MMD_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("%m: check failed");

`endif

/* hw/rtl/mmd_pkg.sv */
// Shared constants and types of the modular arithmetic unit.
`default_nettype none
package mmd_pkg;
    localparam int unsigned MOD_WIDTH_DEFAULT = 32;
    localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_DIV = 2'd1,
        OP_RED = 2'd2,
        OP_NOP = 2'd3
    } opcode_t;
endpackage
`default_nettype wire

/* hw/rtl/mmd_divider.sv */
// Bit-serial restoring divider: quotient and remainder of num / den.
`default_nettype none
module mmd_divider #(
    parameter int unsigned W = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] num,
    input  wire logic [W-1:0] den,
    output logic              done,
    output logic [W-1:0]      quo,
    output logic [W-1:0]      rem
);
    localparam int unsigned CW = $clog2(W + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  q_reg;
    logic [W-1:0]  r_reg;
    logic [W-1:0]  d_reg;
    logic [W:0]    trial;
    logic [W:0]    diff;

    // shift in next dividend bit, subtract if it fits
    assign trial = {r_reg, q_reg[W-1]};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
                q_reg    <= num;
                r_reg    <= '0;
                d_reg    <= den;
            end
            else if (busy_reg)
            begin
                if (!diff[W])
                begin
                    r_reg <= diff[W-1:0];
                    q_reg <= {q_reg[W-2:0], 1'b1};
                end
                else
                begin
                    r_reg <= trial[W-1:0];
                    q_reg <= {q_reg[W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    assign quo = q_reg;
    assign rem = r_reg;
endmodule
`default_nettype wire

/* hw/rtl/mmd_mulmod.sv */
// Bit-serial modular multiplier: (x * y) mod m by double-and-add, x,y < m.
`default_nettype none
module mmd_mulmod #(
    parameter int unsigned W = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] x,
    input  wire logic [W-1:0] y,
    input  wire logic [W-1:0] m,
    output logic              done,
    output logic [W-1:0]      prod
);
    localparam int unsigned CW = $clog2(W + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  acc_reg;
    logic [W-1:0]  y_reg;
    logic [W-1:0]  x_reg;
    logic [W:0]    dbl;
    logic [W-1:0]  dbl_red;
    logic [W:0]    sum;
    logic [W-1:0]  sum_red;

    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m}) ? W'(dbl - {1'b0, m}) : dbl[W-1:0];
        sum     = {1'b0, dbl_red} + (y_reg[W-1] ? {1'b0, x_reg} : '0);
        sum_red = (sum >= {1'b0, m}) ? W'(sum - {1'b0, m}) : sum[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
                acc_reg  <= '0;
                x_reg    <= x;
                y_reg    <= y;
            end
            else if (busy_reg)
            begin
                acc_reg <= sum_red;
                y_reg   <= {y_reg[W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    assign prod = acc_reg;
endmodule
`default_nettype wire

/* hw/rtl/modular_mul_div_unit.sv */
// Top level of the modular multiply / divide / reduce unit.
// One request at a time. Operands are reduced modulo m by a bit-serial
// divider run at full 32-bit width; a reduce is that divider pass on a alone,
// and a multiply then runs a bit-serial double-and-add modular multiplier.
// Divide runs the extended Euclidean iteration: each quotient step costs
// one divider pass and one modular multiply, and a final modular multiply
// forms a times the inverse. The divider and multiplier are shared by all
// operations. The result sits in an output register; s_tready is high
// only when the unit is idle and that register is free. The modulus is
// written through cfg_we/cfg_data, only its low MOD_WIDTH bits are kept,
// and it must be changed only while idle.
`default_nettype none
module modular_mul_div_unit #(
    parameter int unsigned MOD_WIDTH = mmd_pkg::MOD_WIDTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: operand_a [31:0], operand_b [63:32]
    input  wire logic [63:0] s_tdata,
    // tuser: opcode [1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: result_value [31:0]
    output logic [31:0]      m_tdata,
    // tuser: not_invertible [0]
    output logic             m_tuser
);
    localparam int unsigned W = MOD_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE, S_RED_A, S_RED_B, S_MUL, S_EU_DIV, S_EU_MUL, S_FIN_MUL, S_OUT
    } state_t;

    state_t         state_reg;
    logic [W-1:0]   mod_reg;
    mmd_pkg::opcode_t op_reg;
    logic [31:0]    a_in_reg;
    logic [31:0]    b_in_reg;
    logic [W-1:0]   a_reg;      // a mod m
    logic [W-1:0]   num_reg;
    logic [W-1:0]   den_reg;
    logic [W-1:0]   cur_reg;
    logic [W-1:0]   prev_reg;
    logic [W-1:0]   quo_reg;
    logic [W-1:0]   rem_reg;
    logic [31:0]    res_reg;
    logic           flag_reg;
    logic           out_valid_reg;

    // shared divider
    logic           div_start;
    logic [W-1:0]   div_den;
    logic           div_done;
    logic [W-1:0]   div_quo;
    logic [W-1:0]   div_rem;
    logic [31:0]    div_num_w;
    logic [31:0]    div_quo_w;
    logic [31:0]    div_rem_w;
    // shared modular multiplier
    logic           mul_start;
    logic [W-1:0]   mul_x;
    logic [W-1:0]   mul_y;
    logic           mul_done;
    logic [W-1:0]   mul_prod;
    logic           start_reg;
    logic           start_next;

    logic [W:0]     nxt_sum;
    logic [W-1:0]   nxt_val;

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg;
    assign m_tuser  = flag_reg;

    // operands are 32 bits even when W<32, so the divider runs at full
    // 32-bit width to reduce them exactly.
    mmd_divider #(.W(32)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(div_num_w), .den(32'(div_den)),
        .done(div_done), .quo(div_quo_w), .rem(div_rem_w)
    );
    assign div_quo = div_quo_w[W-1:0];
    assign div_rem = div_rem_w[W-1:0];

    mmd_mulmod #(.W(W)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start),
        .x(mul_x), .y(mul_y), .m(mod_reg),
        .done(mul_done), .prod(mul_prod)
    );

    assign div_start = start_reg && (state_reg == S_RED_A || state_reg == S_RED_B
                       || state_reg == S_EU_DIV);
    assign mul_start = start_reg && (state_reg == S_MUL || state_reg == S_EU_MUL
                       || state_reg == S_FIN_MUL);

    always_comb
    begin
        div_num_w = 32'(num_reg);
        div_den   = den_reg;
        if (state_reg == S_RED_A)
        begin
            div_num_w = a_in_reg;
            div_den   = mod_reg;
        end
        else if (state_reg == S_RED_B)
        begin
            div_num_w = b_in_reg;
            div_den   = mod_reg;
        end
        mul_x   = (state_reg == S_EU_MUL) ? cur_reg : a_reg;
        mul_y   = (state_reg == S_EU_MUL) ? quo_reg
                : (state_reg == S_FIN_MUL) ? prev_reg : den_reg;
        // prev - cur*q mod m; mul_prod < m, prev < m
        nxt_sum = {1'b0, prev_reg} + {1'b0, mod_reg} - {1'b0, mul_prod};
        nxt_val = (nxt_sum >= {1'b0, mod_reg}) ? W'(nxt_sum - {1'b0, mod_reg})
                                               : nxt_sum[W-1:0];
    end

    // one-cycle start pulse into the state that launches a divider or multiplier pass
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:
                start_next = s_tvalid && s_tready
                             && (mmd_pkg::opcode_t'(s_tuser) != mmd_pkg::OP_NOP)
                             && (mod_reg != '0);
            S_RED_A:
                start_next = div_done && (op_reg != mmd_pkg::OP_RED);
            S_RED_B:
                start_next = div_done && ((op_reg == mmd_pkg::OP_MUL)
                             || ((mod_reg != W'(1)) && (div_rem != '0)));
            S_EU_DIV:
                start_next = div_done;
            S_EU_MUL:
                start_next = mul_done && ((rem_reg != '0) || (den_reg == W'(1)));
            default:
                start_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mod_reg       <= mmd_pkg::MODULUS_RESET[W-1:0];
            out_valid_reg <= 1'b0;
            start_reg     <= 1'b0;
        end
        else
        begin
            start_reg <= start_next;
            if (cfg_we)
                mod_reg <= cfg_data[W-1:0];
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        op_reg   <= mmd_pkg::opcode_t'(s_tuser);
                        a_in_reg <= s_tdata[31:0];
                        b_in_reg <= s_tdata[63:32];
                        res_reg  <= '0;
                        priority if (mmd_pkg::opcode_t'(s_tuser) == mmd_pkg::OP_NOP)
                        begin
                            flag_reg  <= 1'b0;
                            state_reg <= S_OUT;
                        end
                        else if (mod_reg == '0)
                        begin
                            flag_reg  <= (mmd_pkg::opcode_t'(s_tuser) == mmd_pkg::OP_DIV);
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            flag_reg  <= 1'b0;
                            state_reg <= S_RED_A;
                        end
                    end
                end
                S_RED_A:
                begin
                    if (div_done)
                    begin
                        a_reg <= div_rem;
                        if (op_reg == mmd_pkg::OP_RED)
                        begin
                            res_reg   <= 32'(div_rem);
                            state_reg <= S_OUT;
                        end
                        else
                            state_reg <= S_RED_B;
                    end
                end
                S_RED_B:
                begin
                    if (div_done)
                    begin
                        den_reg <= div_rem;
                        if (op_reg == mmd_pkg::OP_MUL)
                            state_reg <= S_MUL;
                        else if (mod_reg == W'(1))
                            state_reg <= S_OUT;
                        else if (div_rem == '0)
                        begin
                            flag_reg  <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            num_reg   <= mod_reg;
                            cur_reg   <= W'(1);
                            prev_reg  <= '0;
                            state_reg <= S_EU_DIV;
                        end
                    end
                end
                S_MUL:
                begin
                    if (mul_done)
                    begin
                        res_reg   <= 32'(mul_prod);
                        state_reg <= S_OUT;
                    end
                end
                S_EU_DIV:
                begin
                    if (div_done)
                    begin
                        quo_reg   <= div_quo;
                        rem_reg   <= div_rem;
                        state_reg <= S_EU_MUL;
                    end
                end
                S_EU_MUL:
                begin
                    if (mul_done)
                    begin
                        prev_reg <= cur_reg;
                        cur_reg  <= nxt_val;
                        num_reg  <= den_reg;
                        den_reg  <= rem_reg;
                        if (rem_reg == '0)
                        begin
                            // gcd now in den_reg
                            if (den_reg != W'(1))
                            begin
                                flag_reg  <= 1'b1;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                // inverse is cur_reg (becomes prev)
                                state_reg <= S_FIN_MUL;
                            end
                        end
                        else
                            state_reg <= S_EU_DIV;
                    end
                end
                S_FIN_MUL:
                begin
                    if (mul_done)
                    begin
                        res_reg   <= 32'(mul_prod);
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/mmd_checker.sv */
// Port-level checker for the modular arithmetic unit, bound to the top level.
`default_nettype none
`include "modular_mul_div_unit_defines.svh"
module mmd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tuser
);
    // a flagged result always carries zero
    `MMD_ASSERT_IMPL(a_flag_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata == 32'd0)
    // no new request taken while a result waits
    `MMD_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, m_tvalid, !s_tready)
    // accepting a request closes the input until it finishes
    `MMD_ASSERT_NEXT(a_one_at_time, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // a stalled result holds
    `MMD_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tuser))
endmodule

bind modular_mul_div_unit mmd_checker u_mmd_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire

/* tb/tb_modular_mul_div_unit.sv */
// Testbench of the modular multiply / divide / reduce unit: directed table, then random traffic.
`default_nettype none
module tb_modular_mul_div_unit;
    localparam int N_RANDOM = 450;

    // One row of the directed table; chk_exp marks rows whose result is typed in.
    typedef struct {
        logic             wr_mod;
        logic [31:0]      mod_val;
        mmd_pkg::opcode_t op;
        logic [31:0]      a;
        logic [31:0]      b;
        logic             chk_exp;
        logic [31:0]      exp_val;
        logic             exp_flag;
    } vec_t;

    typedef struct {
        logic [31:0] value;
        logic        flag;
    } residue_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;

    logic [31:0] cur_modulus;
    residue_t    pending_residues[$];
    int          errors;
    bit          long_hold;
    bit          stim_done;

    modular_mul_div_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit: ends the run as failed if it has not finished by then.
    initial
    begin
        #200000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Extended Euclid on x mod m; returns the inverse, sets no_inv when gcd != 1.
    function automatic logic [31:0] mod_inverse(input logic [63:0] x, input logic [63:0] m,
                                                output logic no_inv);
        logic [63:0] num, den, rem, quo, cur, prv, nxt;
        num = m;
        den = x;
        cur = 1;
        prv = 0;
        do
        begin
            quo = num / den;
            rem = num % den;
            nxt = ((prv + m) - ((cur * quo) % m)) % m;
            num = den;
            den = rem;
            prv = cur;
            cur = nxt;
        end
        while (rem != 0);
        no_inv = (num != 1);
        return prv[31:0];
    endfunction

    function automatic residue_t mod_result(input mmd_pkg::opcode_t op, input logic [31:0] a,
                                            input logic [31:0] b, input logic [31:0] mod);
        residue_t    r;
        logic [63:0] m, bm, inv;
        logic        ni;
        r.value = '0;
        r.flag  = 1'b0;
        m = {32'd0, mod};
        case (op)
            mmd_pkg::OP_MUL:
                if (m != 0)
                    r.value = (((a % m) * (b % m)) % m);
            mmd_pkg::OP_DIV:
                if (m == 0)
                    r.flag = 1'b1;
                else if (m != 1)
                begin
                    bm = b % m;
                    if (bm == 0)
                        r.flag = 1'b1;
                    else
                    begin
                        inv = {32'd0, mod_inverse(bm, m, ni)};
                        if (ni)
                            r.flag = 1'b1;
                        else
                            r.value = (((a % m) * (inv % m)) % m);
                    end
                end
            mmd_pkg::OP_RED:
                if (m != 0)
                    r.value = a % m;
            default: ;
        endcase
        return r;
    endfunction

    // Write the modulus once the unit is drained.
    task automatic set_modulus(input logic [31:0] v);
        while (pending_residues.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        cur_modulus = v;
    endtask

    task automatic send_request(input mmd_pkg::opcode_t op, input logic [31:0] a,
                                input logic [31:0] b, input bit keep_valid);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_residues.push_back(mod_result(op, a, b, cur_modulus));
        @(negedge clk);
        if (!keep_valid)
            s_tvalid = 1'b0;
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            1: return $urandom_range(0, 20);
            2: return cur_modulus * $urandom_range(0, 3) + $urandom_range(0, 1);
            default: return $urandom;
        endcase
    endfunction

    // Directed table
    vec_t dir_vecs[] = '{
        '{0, 0, mmd_pkg::OP_MUL, 32'd3, 32'd5, 1, 32'd15, 0},
        '{0, 0, mmd_pkg::OP_RED, 32'hFFFF_FFFF, 32'd0, 1, 32'd294967267, 0},
        '{0, 0, mmd_pkg::OP_DIV, 32'd6, 32'd0, 1, 32'd0, 1},
        '{0, 0, mmd_pkg::OP_DIV, 32'd6, 32'd1000000007, 1, 32'd0, 1},
        '{0, 0, mmd_pkg::OP_DIV, 32'd6, 32'd3, 1, 32'd2, 0},
        '{0, 0, mmd_pkg::OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'd0, 0},
        '{0, 0, mmd_pkg::OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0},
        '{1, 32'd12, mmd_pkg::OP_DIV, 32'd7, 32'd8, 1, 32'd0, 1},
        '{0, 0, mmd_pkg::OP_DIV, 32'd7, 32'd5, 0, 0, 0},
        '{1, 32'd0, mmd_pkg::OP_MUL, 32'd7, 32'd9, 1, 32'd0, 0},
        '{0, 0, mmd_pkg::OP_DIV, 32'd7, 32'd9, 1, 32'd0, 1},
        '{0, 0, mmd_pkg::OP_RED, 32'd7, 32'd0, 1, 32'd0, 0},
        '{1, 32'd1, mmd_pkg::OP_DIV, 32'd7, 32'd9, 1, 32'd0, 0},
        '{0, 0, mmd_pkg::OP_MUL, 32'd7, 32'd9, 1, 32'd0, 0},
        '{1, 32'd2, mmd_pkg::OP_DIV, 32'd1, 32'd3, 1, 32'd1, 0},
        '{1, 32'hFFFF_FFFF, mmd_pkg::OP_DIV, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 0, 0, 0},
        '{0, 0, mmd_pkg::OP_DIV, 32'd1, 32'd3, 1, 32'd0, 1},
        '{0, 0, mmd_pkg::OP_MUL, 32'hFFFF_FFFF, 32'd2, 1, 32'd0, 0},
        '{0, 0, mmd_pkg::OP_RED, 32'hFFFF_FFFE, 32'd0, 1, 32'hFFFF_FFFE, 0},
        '{1, 32'hFFFF_FFFB, mmd_pkg::OP_DIV, 32'h1234_5678, 32'h8765_4321, 0, 0, 0}
    };

    // Stimulus
    initial
    begin
        int               burst;
        residue_t         r;
        mmd_pkg::opcode_t op;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        rst_n       = 1'b0;
        errors      = 0;
        long_hold   = 0;
        stim_done   = 0;
        cur_modulus = mmd_pkg::MODULUS_RESET;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_vecs[i])
        begin
            if (dir_vecs[i].wr_mod)
                set_modulus(dir_vecs[i].mod_val);
            r = mod_result(dir_vecs[i].op, dir_vecs[i].a, dir_vecs[i].b, cur_modulus);
            if (dir_vecs[i].chk_exp &&
                (r.value !== dir_vecs[i].exp_val || r.flag !== dir_vecs[i].exp_flag))
            begin
                $display("%0t table row %0d: expected %h/%b, predicted %h/%b", $time, i,
                         dir_vecs[i].exp_val, dir_vecs[i].exp_flag, r.value, r.flag);
                errors++;
            end
            send_request(dir_vecs[i].op, dir_vecs[i].a, dir_vecs[i].b, 0);
        end

        // Random phases over several moduli, small ones included for frequent non-units.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_modulus(32'd1000000007);
                1: set_modulus($urandom_range(2, 300));
                2: set_modulus(32'hFFFF_FFFF);
                3: set_modulus($urandom);
                4: set_modulus(32'd2);
                default: set_modulus($urandom | 32'h8000_0000);
            endcase
            if (ph == 1)
                long_hold = 1;
            for (int n = 0; n < N_RANDOM / 6; )
            begin
                burst = $urandom_range(1, 8);
                for (int k = 0; k < burst && n < N_RANDOM / 6; k++, n++)
                begin
                    op = mmd_pkg::opcode_t'($urandom_range(0, 9) < 9 ?
                                            $urandom_range(0, 2) : 3);
                    send_request(op, rand_operand(), rand_operand(),
                                 k + 1 < burst && n + 1 < N_RANDOM / 6);
                end
                repeat ($urandom_range(0, 4)) @(negedge clk);
            end
        end
        stim_done = 1;
    end

    // Receiver: random stalls, plus one long hold-off while requests keep coming.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                long_hold = 0;
                m_tready <= 1'b0;
                repeat (3000) @(negedge clk);
            end
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Checker
    always @(posedge clk)
    begin
        residue_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_residues.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %h/%b", $time,
                         m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                e = pending_residues.pop_front();
                if (m_tdata !== e.value)
                begin
                    $display("%0t result_value: expected %h, actual %h", $time, e.value, m_tdata);
                    errors++;
                end
                if (m_tuser !== e.flag)
                begin
                    $display("%0t not_invertible: expected %b, actual %b", $time, e.flag, m_tuser);
                    errors++;
                end
            end
        end
    end

    // End of run
    initial
    begin
        wait (stim_done);
        while (pending_residues.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
